// ----- hdl/gfc_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, register codes and stage records for the gravity force pipeline
package gfc_pkg;

  localparam int POS_BITS       = 48;
  localparam int MASS_BITS      = 32;
  localparam int GRAV_FRAC_BITS = 16;
  localparam int GRAV_BITS      = 32;
  localparam int SHIFT_BITS     = 6;
  localparam int FORCE_BITS     = 64;

  localparam int DIFF_BITS = POS_BITS + 1;
  localparam int MAG_BITS  = POS_BITS;
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int R2_BITS   = SQ_BITS + 1;
  localparam int ROOT_BITS = (R2_BITS + 1) / 2;
  localparam int GM1_BITS  = GRAV_BITS + MASS_BITS;
  localparam int NUM_BITS  = GRAV_BITS + 2 * MASS_BITS;
  localparam int DEN_BITS  = R2_BITS + ROOT_BITS;
  localparam int PROD_BITS = NUM_BITS + MAG_BITS;
  localparam int Q_BITS    = NUM_BITS;
  localparam int SH_BITS   = SHIFT_BITS + 1;
  localparam int CMP_BITS  = (Q_BITS > FORCE_BITS) ? Q_BITS : FORCE_BITS;

  localparam int DIG         = 8;
  localparam int SQ_DIGS     = (MAG_BITS + DIG - 1) / DIG;
  localparam int MASS_DIGS   = (MASS_BITS + DIG - 1) / DIG;
  localparam int PREP_STAGES = (SQ_DIGS > MASS_DIGS) ? SQ_DIGS : MASS_DIGS;
  localparam int SQ_EXT      = PREP_STAGES * DIG;
  localparam int MUL_DIGS    = (ROOT_BITS + DIG - 1) / DIG;
  localparam int MUL_EXT     = MUL_DIGS * DIG;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRAV_CONST  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FORCE_SHIFT = 2'd1;

  typedef struct packed {
    logic [MAG_BITS-1:0] adx;
    logic [MAG_BITS-1:0] ady;
    logic                negx;
    logic                negy;
    logic                coin;
    logic [NUM_BITS-1:0] num;
    logic [R2_BITS-1:0]  r2;
  } geo_t;

  typedef struct packed {
    geo_t                 geo;
    logic [ROOT_BITS-1:0] root;
  } root_t;

  typedef struct packed {
    logic                 negx;
    logic                 negy;
    logic                 coin;
    logic [DEN_BITS-1:0]  den;
    logic [PROD_BITS-1:0] px;
    logic [PROD_BITS-1:0] py;
  } quo_in_t;

  typedef struct packed {
    logic              negx;
    logic              negy;
    logic              coin;
    logic [Q_BITS-1:0] qx;
    logic [Q_BITS-1:0] qy;
  } quo_t;

endpackage

// ----- hdl/pairwise_gravity_force_core.sv -----
`timescale 1ns / 1ps
// top level of the pairwise gravity force pipeline with config registers and output stage
//
//  channel  | handshake              | word
//  ---------+------------------------+----------------------------------------------
//  in       | in_valid_i/in_ready_o  | two positions and two masses
//  out      | out_valid_o/out_ready_i| force_x, force_y, coincident, saturated
//  cfg      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  one word in per cycle while the output does not hold the pipe; the deepest parts are the
//  49-stage square root and the 96-stage divider
//  reset clears every valid bit and both config registers
//  the whole pipe holds while a result waits at the output, unless the stage before
//  the output register is empty, in which case words keep entering
module pairwise_gravity_force_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [gfc_pkg::POS_BITS-1:0]   first_x_i,
  input  logic signed [gfc_pkg::POS_BITS-1:0]   first_y_i,
  input  logic signed [gfc_pkg::POS_BITS-1:0]   second_x_i,
  input  logic signed [gfc_pkg::POS_BITS-1:0]   second_y_i,
  input  logic        [gfc_pkg::MASS_BITS-1:0]  first_mass_i,
  input  logic        [gfc_pkg::MASS_BITS-1:0]  second_mass_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [gfc_pkg::FORCE_BITS-1:0] force_x_o,
  output logic signed [gfc_pkg::FORCE_BITS-1:0] force_y_o,
  output logic                                  coincident_o,
  output logic                                  saturated_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [gfc_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [gfc_pkg::GRAV_BITS-1:0]         cfg_data_i
);
  import gfc_pkg::*;

  typedef struct packed {
    logic              negx;
    logic              negy;
    logic              coin;
    logic [Q_BITS-1:0] mx;
    logic [Q_BITS-1:0] my;
  } fin_t;

  function automatic logic [FORCE_BITS:0] clip(logic [Q_BITS-1:0] m, logic neg);
    logic [CMP_BITS-1:0]   me, lim;
    logic [FORCE_BITS-1:0] v;
    logic                  s;
    me  = CMP_BITS'(m);
    lim = (CMP_BITS'(1) << (FORCE_BITS - 1)) - CMP_BITS'(!neg);
    s   = me > lim;
    if (s) begin
      me = lim;
    end
    v = me[FORCE_BITS-1:0];
    if (neg) begin
      v = ~v + 1'b1;
    end
    return {s, v};
  endfunction

  logic [GRAV_BITS-1:0]  grav_q;
  logic [SHIFT_BITS-1:0] shift_q;
  logic                  pipe_en, out_load;
  logic                  geo_v, root_v, mul_v, div_v;
  geo_t                  geo;
  root_t                 root;
  quo_in_t               qin;
  quo_t                  quo;
  logic [SH_BITS-1:0]    sh;
  fin_t                  fin_q;
  logic                  fin_v_q;
  logic [FORCE_BITS:0]   cx, cy;
  logic                  out_valid_q;
  logic [FORCE_BITS-1:0] force_x_q, force_y_q;
  logic                  coin_q, sat_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= '0;
      shift_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GRAV_CONST:  grav_q  <= cfg_data_i;
        CFG_FORCE_SHIFT: shift_q <= cfg_data_i[SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign out_load   = !out_valid_q || out_ready_i;
  assign pipe_en    = out_load || !fin_v_q;
  assign in_ready_o = pipe_en;

  gfc_prep u_prep (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (pipe_en),
    .valid_i            (in_valid_i),
    .first_x_i          (first_x_i),
    .first_y_i          (first_y_i),
    .second_x_i         (second_x_i),
    .second_y_i         (second_y_i),
    .first_mass_i       (first_mass_i),
    .second_mass_i      (second_mass_i),
    .gravity_constant_i (grav_q),
    .valid_o            (geo_v),
    .geo_o              (geo)
  );

  gfc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (geo_v),
    .geo_i   (geo),
    .valid_o (root_v),
    .root_o  (root)
  );

  gfc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (root_v),
    .root_i  (root),
    .valid_o (mul_v),
    .quo_o   (qin)
  );

  gfc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (mul_v),
    .quo_i   (qin),
    .valid_o (div_v),
    .quo_o   (quo)
  );

  assign sh = SH_BITS'(GRAV_FRAC_BITS) + SH_BITS'(shift_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (pipe_en) begin
      fin_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      fin_q.negx <= quo.negx;
      fin_q.negy <= quo.negy;
      fin_q.coin <= quo.coin;
      fin_q.mx   <= quo.qx >> sh;
      fin_q.my   <= quo.qy >> sh;
    end
  end

  assign cx = clip(fin_q.mx, fin_q.negx);
  assign cy = clip(fin_q.my, fin_q.negy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= fin_v_q;
    end
  end

  // coincident bodies give zero force and no clipping
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      coin_q <= fin_q.coin;
      if (fin_q.coin) begin
        force_x_q <= '0;
        force_y_q <= '0;
        sat_q     <= 1'b0;
      end else begin
        force_x_q <= cx[FORCE_BITS-1:0];
        force_y_q <= cy[FORCE_BITS-1:0];
        sat_q     <= cx[FORCE_BITS] || cy[FORCE_BITS];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign force_x_o    = force_x_q;
  assign force_y_o    = force_y_q;
  assign coincident_o = coin_q;
  assign saturated_o  = sat_q;

endmodule

// ----- hdl/gfc_prep.sv -----
`timescale 1ns / 1ps
// front end: axis differences, mass product and squared distance
module gfc_prep (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [gfc_pkg::POS_BITS-1:0]  first_x_i,
  input  logic signed [gfc_pkg::POS_BITS-1:0]  first_y_i,
  input  logic signed [gfc_pkg::POS_BITS-1:0]  second_x_i,
  input  logic signed [gfc_pkg::POS_BITS-1:0]  second_y_i,
  input  logic        [gfc_pkg::MASS_BITS-1:0] first_mass_i,
  input  logic        [gfc_pkg::MASS_BITS-1:0] second_mass_i,
  input  logic        [gfc_pkg::GRAV_BITS-1:0] gravity_constant_i,
  output logic                                 valid_o,
  output gfc_pkg::geo_t                        geo_o
);
  import gfc_pkg::*;

  typedef struct packed {
    logic [MAG_BITS-1:0]  adx;
    logic [MAG_BITS-1:0]  ady;
    logic                 negx;
    logic                 negy;
    logic                 coin;
    logic [GM1_BITS-1:0]  gm1;
    logic [MASS_BITS-1:0] m2;
    logic [SQ_BITS-1:0]   sqx;
    logic [SQ_BITS-1:0]   sqy;
    logic [NUM_BITS-1:0]  num;
  } prep_t;

  logic [DIFF_BITS-1:0] dx, dy, ax, ay;
  prep_t                ld;
  prep_t                st_q [PREP_STAGES+1];
  logic                 v_q  [PREP_STAGES+1];
  geo_t                 geo_q;
  logic                 geo_v_q;

  always_comb begin
    dx = {second_x_i[POS_BITS-1], second_x_i} - {first_x_i[POS_BITS-1], first_x_i};
    dy = {second_y_i[POS_BITS-1], second_y_i} - {first_y_i[POS_BITS-1], first_y_i};
    ax = dx[DIFF_BITS-1] ? (~dx + 1'b1) : dx;
    ay = dy[DIFF_BITS-1] ? (~dy + 1'b1) : dy;
    ld.adx  = ax[MAG_BITS-1:0];
    ld.ady  = ay[MAG_BITS-1:0];
    ld.negx = dx[DIFF_BITS-1];
    ld.negy = dy[DIFF_BITS-1];
    ld.coin = (dx == '0) && (dy == '0);
    ld.gm1  = GM1_BITS'(gravity_constant_i) * GM1_BITS'(first_mass_i);
    ld.m2   = second_mass_i;
    ld.sqx  = '0;
    ld.sqy  = '0;
    ld.num  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= ld;
    end
  end

  for (genvar k = 0; k < PREP_STAGES; k++) begin : g_mac
    logic [SQ_BITS-1:0]  sqx_n, sqy_n;
    logic [NUM_BITS-1:0] num_n;
    prep_t               nxt;

    if (k < SQ_DIGS) begin : g_sq
      logic [SQ_EXT-1:0]       ex, ey;
      logic [MAG_BITS+DIG-1:0] ppx, ppy;
      assign ex    = SQ_EXT'(st_q[k].adx);
      assign ey    = SQ_EXT'(st_q[k].ady);
      assign ppx   = st_q[k].adx * ex[k*DIG +: DIG];
      assign ppy   = st_q[k].ady * ey[k*DIG +: DIG];
      assign sqx_n = st_q[k].sqx + (SQ_BITS'(ppx) << (k * DIG));
      assign sqy_n = st_q[k].sqy + (SQ_BITS'(ppy) << (k * DIG));
    end else begin : g_sq_hold
      assign sqx_n = st_q[k].sqx;
      assign sqy_n = st_q[k].sqy;
    end

    if (k < MASS_DIGS) begin : g_num
      logic [SQ_EXT-1:0]       em;
      logic [GM1_BITS+DIG-1:0] ppm;
      assign em    = SQ_EXT'(st_q[k].m2);
      assign ppm   = st_q[k].gm1 * em[k*DIG +: DIG];
      assign num_n = st_q[k].num + (NUM_BITS'(ppm) << (k * DIG));
    end else begin : g_num_hold
      assign num_n = st_q[k].num;
    end

    always_comb begin
      nxt     = st_q[k];
      nxt.sqx = sqx_n;
      nxt.sqy = sqy_n;
      nxt.num = num_n;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo_v_q <= 1'b0;
    end else if (en_i) begin
      geo_v_q <= v_q[PREP_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_q.adx  <= st_q[PREP_STAGES].adx;
      geo_q.ady  <= st_q[PREP_STAGES].ady;
      geo_q.negx <= st_q[PREP_STAGES].negx;
      geo_q.negy <= st_q[PREP_STAGES].negy;
      geo_q.coin <= st_q[PREP_STAGES].coin;
      geo_q.num  <= st_q[PREP_STAGES].num;
      geo_q.r2   <= R2_BITS'(st_q[PREP_STAGES].sqx) + R2_BITS'(st_q[PREP_STAGES].sqy);
    end
  end

  assign valid_o = geo_v_q;
  assign geo_o   = geo_q;

endmodule

// ----- hdl/gfc_isqrt.sv -----
`timescale 1ns / 1ps
// pipelined integer square root of the squared distance, one root bit per stage
module gfc_isqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  gfc_pkg::geo_t  geo_i,
  output logic           valid_o,
  output gfc_pkg::root_t root_o
);
  import gfc_pkg::*;

  localparam int TR_BITS = R2_BITS + 1;

  typedef struct packed {
    geo_t                 geo;
    logic [R2_BITS-1:0]   rem;
    logic [ROOT_BITS-1:0] root;
  } sq_t;

  sq_t  cur  [ROOT_BITS];
  sq_t  st_q [ROOT_BITS];
  logic vin  [ROOT_BITS];
  logic v_q  [ROOT_BITS];

  assign cur[0].geo  = geo_i;
  assign cur[0].rem  = geo_i.r2;
  assign cur[0].root = '0;
  assign vin[0]      = valid_i;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_bit
    localparam int B = ROOT_BITS - 1 - k;
    logic [TR_BITS-1:0] trial;
    logic               take;
    sq_t                nxt;

    if (k > 0) begin : g_link
      assign cur[k] = st_q[k-1];
      assign vin[k] = v_q[k-1];
    end

    assign trial = (TR_BITS'(cur[k].root) << (B + 1)) | (TR_BITS'(1) << (2 * B));
    assign take  = {1'b0, cur[k].rem} >= trial;

    always_comb begin
      nxt = cur[k];
      if (take) begin
        nxt.rem     = cur[k].rem - trial[R2_BITS-1:0];
        nxt.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vin[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign valid_o     = v_q[ROOT_BITS-1];
  assign root_o.geo  = st_q[ROOT_BITS-1].geo;
  assign root_o.root = st_q[ROOT_BITS-1].root;

endmodule

// ----- hdl/gfc_mul.sv -----
`timescale 1ns / 1ps
// digit-serial products: denominator r2*root and the two numerators num*|d|
module gfc_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  gfc_pkg::root_t   root_i,
  output logic             valid_o,
  output gfc_pkg::quo_in_t quo_o
);
  import gfc_pkg::*;

  typedef struct packed {
    logic                 negx;
    logic                 negy;
    logic                 coin;
    logic [R2_BITS-1:0]   r2;
    logic [ROOT_BITS-1:0] root;
    logic [NUM_BITS-1:0]  num;
    logic [MAG_BITS-1:0]  adx;
    logic [MAG_BITS-1:0]  ady;
    logic [DEN_BITS-1:0]  den;
    logic [PROD_BITS-1:0] px;
    logic [PROD_BITS-1:0] py;
  } mul_t;

  mul_t cur  [MUL_DIGS];
  mul_t st_q [MUL_DIGS];
  logic vin  [MUL_DIGS];
  logic v_q  [MUL_DIGS];

  always_comb begin
    cur[0].negx = root_i.geo.negx;
    cur[0].negy = root_i.geo.negy;
    cur[0].coin = root_i.geo.coin;
    cur[0].r2   = root_i.geo.r2;
    cur[0].root = root_i.root;
    cur[0].num  = root_i.geo.num;
    cur[0].adx  = root_i.geo.adx;
    cur[0].ady  = root_i.geo.ady;
    cur[0].den  = '0;
    cur[0].px   = '0;
    cur[0].py   = '0;
  end
  assign vin[0] = valid_i;

  for (genvar k = 0; k < MUL_DIGS; k++) begin : g_dig
    logic [MUL_EXT-1:0]       er, ex, ey;
    logic [R2_BITS+DIG-1:0]   ppd;
    logic [NUM_BITS+DIG-1:0]  ppx, ppy;
    mul_t                     nxt;

    if (k > 0) begin : g_link
      assign cur[k] = st_q[k-1];
      assign vin[k] = v_q[k-1];
    end

    assign er  = MUL_EXT'(cur[k].root);
    assign ex  = MUL_EXT'(cur[k].adx);
    assign ey  = MUL_EXT'(cur[k].ady);
    assign ppd = cur[k].r2 * er[k*DIG +: DIG];
    assign ppx = cur[k].num * ex[k*DIG +: DIG];
    assign ppy = cur[k].num * ey[k*DIG +: DIG];

    always_comb begin
      nxt     = cur[k];
      nxt.den = cur[k].den + (DEN_BITS'(ppd) << (k * DIG));
      nxt.px  = cur[k].px + (PROD_BITS'(ppx) << (k * DIG));
      nxt.py  = cur[k].py + (PROD_BITS'(ppy) << (k * DIG));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vin[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign valid_o    = v_q[MUL_DIGS-1];
  assign quo_o.negx = st_q[MUL_DIGS-1].negx;
  assign quo_o.negy = st_q[MUL_DIGS-1].negy;
  assign quo_o.coin = st_q[MUL_DIGS-1].coin;
  assign quo_o.den  = st_q[MUL_DIGS-1].den;
  assign quo_o.px   = st_q[MUL_DIGS-1].px;
  assign quo_o.py   = st_q[MUL_DIGS-1].py;

endmodule

// ----- hdl/gfc_div.sv -----
`timescale 1ns / 1ps
// pipelined restoring division of both numerators by the shared denominator
module gfc_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  gfc_pkg::quo_in_t quo_i,
  output logic             valid_o,
  output gfc_pkg::quo_t    quo_o
);
  import gfc_pkg::*;

  typedef struct packed {
    logic                 negx;
    logic                 negy;
    logic                 coin;
    logic [DEN_BITS-1:0]  den;
    logic [PROD_BITS-1:0] px;
    logic [PROD_BITS-1:0] py;
    logic [DEN_BITS-1:0]  remx;
    logic [DEN_BITS-1:0]  remy;
    logic [Q_BITS-1:0]    qx;
    logic [Q_BITS-1:0]    qy;
  } div_t;

  div_t cur  [Q_BITS];
  div_t st_q [Q_BITS];
  logic vin  [Q_BITS];
  logic v_q  [Q_BITS];

  // upper quotient bits are known zero, so the top numerator bits preload the remainder
  always_comb begin
    cur[0].negx = quo_i.negx;
    cur[0].negy = quo_i.negy;
    cur[0].coin = quo_i.coin;
    cur[0].den  = quo_i.den;
    cur[0].px   = quo_i.px;
    cur[0].py   = quo_i.py;
    cur[0].remx = DEN_BITS'(quo_i.px >> Q_BITS);
    cur[0].remy = DEN_BITS'(quo_i.py >> Q_BITS);
    cur[0].qx   = '0;
    cur[0].qy   = '0;
  end
  assign vin[0] = valid_i;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_bit
    localparam int B = Q_BITS - 1 - k;
    logic [DEN_BITS:0] tx, ty, dd;
    logic              okx, oky;
    div_t              nxt;

    if (k > 0) begin : g_link
      assign cur[k] = st_q[k-1];
      assign vin[k] = v_q[k-1];
    end

    assign tx  = {cur[k].remx, cur[k].px[B]};
    assign ty  = {cur[k].remy, cur[k].py[B]};
    assign dd  = {1'b0, cur[k].den};
    assign okx = tx >= dd;
    assign oky = ty >= dd;

    always_comb begin
      nxt       = cur[k];
      nxt.remx  = okx ? DEN_BITS'(tx - dd) : tx[DEN_BITS-1:0];
      nxt.remy  = oky ? DEN_BITS'(ty - dd) : ty[DEN_BITS-1:0];
      nxt.qx[B] = okx;
      nxt.qy[B] = oky;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vin[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign valid_o    = v_q[Q_BITS-1];
  assign quo_o.negx = st_q[Q_BITS-1].negx;
  assign quo_o.negy = st_q[Q_BITS-1].negy;
  assign quo_o.coin = st_q[Q_BITS-1].coin;
  assign quo_o.qx   = st_q[Q_BITS-1].qx;
  assign quo_o.qy   = st_q[Q_BITS-1].qy;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for the gravity force pipeline: random and directed words against a predictor
module tb_top;
  import gfc_pkg::*;

  typedef logic [255:0] wide_t;

  typedef struct {
    logic signed [FORCE_BITS-1:0] fx;
    logic signed [FORCE_BITS-1:0] fy;
    logic                         coin;
    logic                         sat;
  } force_word_t;

  class force_scoreboard;
    logic [GRAV_BITS-1:0]  grav;
    logic [SHIFT_BITS-1:0] shift;
    force_word_t           pending[$];
    int                    errs;

    function new();
      grav = '0;
      shift = '0;
      errs = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [GRAV_BITS-1:0] data);
      if (idx == CFG_GRAV_CONST) grav = data;
      else if (idx == CFG_FORCE_SHIFT) shift = data[SHIFT_BITS-1:0];
    endfunction

    function logic [FORCE_BITS-1:0] axis_force(wide_t num, wide_t den, wide_t ad, logic neg,
                                               ref logic sat);
      wide_t q;
      wide_t lim;
      q = (num * ad) / den;
      q = q >> (GRAV_FRAC_BITS + shift);
      lim = neg ? (wide_t'(1) << 63) : ((wide_t'(1) << 63) - 1);
      if (q > lim) begin
        q = lim;
        sat = 1'b1;
      end
      return neg ? -q[FORCE_BITS-1:0] : q[FORCE_BITS-1:0];
    endfunction

    function void note(logic signed [POS_BITS-1:0] x1, logic signed [POS_BITS-1:0] y1,
                       logic signed [POS_BITS-1:0] x2, logic signed [POS_BITS-1:0] y2,
                       logic [MASS_BITS-1:0] m1, logic [MASS_BITS-1:0] m2);
      logic signed [POS_BITS:0] dx, dy;
      wide_t ax, ay, r2, root, c, num, den;
      force_word_t w;
      dx = $signed({x2[POS_BITS-1], x2}) - $signed({x1[POS_BITS-1], x1});
      dy = $signed({y2[POS_BITS-1], y2}) - $signed({y1[POS_BITS-1], y1});
      w.sat = 1'b0;
      if (dx == 0 && dy == 0) begin
        w.fx = '0;
        w.fy = '0;
        w.coin = 1'b1;
      end else begin
        ax = dx[POS_BITS] ? wide_t'(-dx) : wide_t'(dx);
        ay = dy[POS_BITS] ? wide_t'(-dy) : wide_t'(dy);
        ax = ax & ((wide_t'(1) << (POS_BITS + 1)) - 1);
        ay = ay & ((wide_t'(1) << (POS_BITS + 1)) - 1);
        r2 = ax * ax + ay * ay;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
          c = root | (wide_t'(1) << b);
          if (c * c <= r2) root = c;
        end
        den = r2 * root;
        num = wide_t'(grav) * wide_t'(m1) * wide_t'(m2);
        w.coin = 1'b0;
        w.fx = axis_force(num, den, ax, dx[POS_BITS], w.sat);
        w.fy = axis_force(num, den, ay, dy[POS_BITS], w.sat);
      end
      pending.push_back(w);
    endfunction

    function void check(force_word_t got);
      force_word_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected word exp none got fx %h fy %h", $time, got.fx, got.fy);
        errs++;
        return;
      end
      e = pending.pop_front();
      if (got.fx !== e.fx) begin
        $display("%0t force_x exp %h got %h", $time, e.fx, got.fx);
        errs++;
      end
      if (got.fy !== e.fy) begin
        $display("%0t force_y exp %h got %h", $time, e.fy, got.fy);
        errs++;
      end
      if (got.coin !== e.coin) begin
        $display("%0t coincident exp %b got %b", $time, e.coin, got.coin);
        errs++;
      end
      if (got.sat !== e.sat) begin
        $display("%0t saturated exp %b got %b", $time, e.sat, got.sat);
        errs++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic signed [POS_BITS-1:0] fx1, fy1, sx2, sy2;
  logic [MASS_BITS-1:0] m1, m2;
  logic signed [FORCE_BITS-1:0] force_x, force_y;
  logic coin, sat;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [GRAV_BITS-1:0] cfg_data;

  force_scoreboard sb;
  int n_in, n_cfg, hold_cycles;
  bit quiet;

  pairwise_gravity_force_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .first_x_i(fx1), .first_y_i(fy1), .second_x_i(sx2), .second_y_i(sy2),
    .first_mass_i(m1), .second_mass_i(m2),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .force_x_o(force_x), .force_y_o(force_y), .coincident_o(coin), .saturated_o(sat),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    force_word_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note(fx1, fy1, sx2, sy2, m1, m2);
        n_in++;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_idx, cfg_data);
        n_cfg++;
      end
      if (out_valid && out_ready) begin
        got.fx = force_x;
        got.fy = force_y;
        got.coin = coin;
        got.sat = sat;
        sb.check(got);
      end
    end
  end

  // receiver: random stall bursts, long hold on request
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 12);
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic signed [POS_BITS-1:0] a, logic signed [POS_BITS-1:0] b,
                           logic signed [POS_BITS-1:0] c, logic signed [POS_BITS-1:0] d,
                           logic [MASS_BITS-1:0] ma, logic [MASS_BITS-1:0] mb);
    int gap, target;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    fx1 <= a; fy1 <= b; sx2 <= c; sy2 <= d; m1 <= ma; m2 <= mb;
    in_valid <= 1'b1;
    target = n_in + 1;
    do @(negedge clk); while (n_in != target);
  endtask

  task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [GRAV_BITS-1:0] data);
    int target;
    in_valid <= 1'b0;
    cfg_idx <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    target = n_cfg + 1;
    do @(negedge clk); while (n_cfg != target);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [MASS_BITS-1:0] rnd_mass();
    logic [MASS_BITS-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return v >> $urandom_range(0, MASS_BITS - 1);
      default: return v;
    endcase
  endfunction

  task automatic random_words(int count);
    logic signed [POS_BITS-1:0] a, b, c, d;
    logic [63:0] dlt;
    int k;
    for (int i = 0; i < count; i++) begin
      a = POS_BITS'(rnd64());
      b = POS_BITS'(rnd64());
      k = $urandom_range(0, 9);
      if (k == 0) begin
        c = POS_BITS'(rnd64());
        d = POS_BITS'(rnd64());
      end else if (k == 1) begin
        c = a;
        d = b;
      end else begin
        dlt = rnd64() >> $urandom_range(16, 63);
        c = $urandom_range(0, 1) ? a + dlt[POS_BITS-1:0] : a - dlt[POS_BITS-1:0];
        dlt = rnd64() >> $urandom_range(16, 63);
        d = $urandom_range(0, 1) ? b + dlt[POS_BITS-1:0] : b - dlt[POS_BITS-1:0];
      end
      send_word(a, b, c, d, rnd_mass(), rnd_mass());
    end
  endtask

  localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};
  localparam logic [MASS_BITS-1:0] MMAX = '1;

  initial begin
    sb = new();
    n_in = 0;
    n_cfg = 0;
    hold_cycles = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_idx = CFG_GRAV_CONST;
    cfg_data = '0;
    fx1 = '0; fy1 = '0; sx2 = '0; sy2 = '0; m1 = '0; m2 = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset values: zero gravity
    send_word(0, 0, 5, 7, MMAX, MMAX);
    send_word(3, 3, 3, 3, MMAX, MMAX);
    drain();

    write_cfg(CFG_GRAV_CONST, '1);
    write_cfg(CFG_FORCE_SHIFT, 32'd0);
    send_word(1, 1, 1, 1, MMAX, MMAX);
    send_word(PMIN, PMIN, PMAX, PMAX, MMAX, MMAX);
    send_word(PMAX, PMAX, PMIN, PMIN, MMAX, MMAX);
    send_word(PMAX, 0, PMIN, 0, MMAX, MMAX);
    send_word(0, PMIN, 0, PMAX, MMAX, MMAX);
    send_word(0, 0, 1, 0, MMAX, MMAX);
    send_word(0, 0, 0, -1, MMAX, MMAX);
    send_word(0, 0, -1, 1, MMAX, MMAX);
    send_word(0, 0, 1, 1, 0, MMAX);
    send_word(0, 0, 1, 1, MMAX, 0);
    send_word(-5, 9, 1000, -2000, 1, 1);
    send_word(PMAX, PMIN, PMAX, PMIN, 0, 0);
    send_word(-1, -1, 0, 0, MMAX, MMAX);
    drain();

    write_cfg(CFG_FORCE_SHIFT, 32'd63);
    send_word(0, 0, 1, 0, MMAX, MMAX);
    send_word(0, 0, -1, -1, MMAX, MMAX);
    random_words(150);
    drain();

    // unknown register indexes are ignored
    write_cfg(2'd2, 32'h0000_0001);
    write_cfg(2'd3, 32'h0000_0003);
    write_cfg(CFG_FORCE_SHIFT, 32'd0);
    random_words(350);
    drain();

    write_cfg(CFG_GRAV_CONST, 32'd1);
    write_cfg(CFG_FORCE_SHIFT, 32'd5);
    random_words(100);
    hold_cycles = 400;
    random_words(300);
    drain();

    write_cfg(CFG_GRAV_CONST, $urandom);
    write_cfg(CFG_FORCE_SHIFT, $urandom_range(0, 20));
    random_words(400);
    drain();

    write_cfg(CFG_GRAV_CONST, 32'h0001_0000);
    write_cfg(CFG_FORCE_SHIFT, 32'd0);
    quiet = 1'b1;
    random_words(500);
    drain();

    if (sb.errs == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
